// File: src/cnalu_pkg.sv
package cnalu_pkg;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4,
    MODE_MAG = 3'd5,
    MODE_ARG = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // quotient bits of the divider, root bits of the square root
  localparam int DIV_BITS   = 33;
  localparam int SQRT_BITS  = 32;
  localparam int ATAN_ENTRIES = 24;
  localparam int ANGLE_BITS = 30;
  localparam int CX_W = 44;
  localparam int CZ_W = 35;
  localparam logic [CZ_W-1:0] PI_Q30 = 35'd3373259426;

  typedef struct packed {
    logic [63:0]     den;
    logic [63:0]     dr_re;
    logic [32:0]     dq_re;
    logic [32:0]     dn_re;
    logic [63:0]     dr_im;
    logic [32:0]     dq_im;
    logic [32:0]     dn_im;
    logic [63:0]     sq_v;
    logic [34:0]     sq_rem;
    logic [31:0]     sq_root;
    logic [CX_W-1:0] cx;
    logic [CX_W-1:0] cy;
    logic [CZ_W-1:0] cz;
    logic            cspec;
  } iter_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        eq;
    logic [31:0] e_re;
    logic [31:0] e_im;
    logic        e_sat;
    logic        re_neg;
    logic        im_neg;
    logic        re_ovf;
    logic        im_ovf;
    logic        den_zero;
  } side_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } pack_t;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // sign and magnitude to saturated 32-bit two's complement
  function automatic pack_t pack32(input logic neg, input logic [63:0] mag);
    pack_t p;
    p.sat = 1'b0;
    if (!neg) begin
      if (mag > 64'h7fff_ffff) begin
        p.sat = 1'b1;
        p.val = 32'h7fff_ffff;
      end else begin
        p.val = mag[31:0];
      end
    end else begin
      if (mag > 64'h8000_0000) begin
        p.sat = 1'b1;
        p.val = 32'h8000_0000;
      end else begin
        p.val = 32'd0 - mag[31:0];
      end
    end
    return p;
  endfunction

endpackage

// File: src/cnalu_iter_stage.sv
module cnalu_iter_stage #(
  parameter int STEP = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk_i,
  input  cnalu_pkg::iter_t  s_i,
  output cnalu_pkg::iter_t  s_o
);

  cnalu_pkg::iter_t s_d, s_q;
  logic [63:0] r_re, r_im;
  logic [34:0] rem, trial;
  logic [cnalu_pkg::CX_W-1:0] xs, ys;
  logic [cnalu_pkg::CZ_W-1:0] at;

  always_comb begin
    s_d = s_i;

    // one quotient bit per stage for each part
    r_re = {s_i.dr_re[62:0], s_i.dn_re[32]};
    r_im = {s_i.dr_im[62:0], s_i.dn_im[32]};
    s_d.dn_re = {s_i.dn_re[31:0], 1'b0};
    s_d.dn_im = {s_i.dn_im[31:0], 1'b0};
    if (r_re >= s_i.den) begin
      s_d.dr_re = r_re - s_i.den;
      s_d.dq_re = {s_i.dq_re[31:0], 1'b1};
    end else begin
      s_d.dr_re = r_re;
      s_d.dq_re = {s_i.dq_re[31:0], 1'b0};
    end
    if (r_im >= s_i.den) begin
      s_d.dr_im = r_im - s_i.den;
      s_d.dq_im = {s_i.dq_im[31:0], 1'b1};
    end else begin
      s_d.dr_im = r_im;
      s_d.dq_im = {s_i.dq_im[31:0], 1'b0};
    end

    // one root bit per stage
    rem   = {s_i.sq_rem[32:0], s_i.sq_v[63:62]};
    trial = {1'b0, s_i.sq_root, 2'b01};
    if (STEP < cnalu_pkg::SQRT_BITS) begin
      s_d.sq_v = {s_i.sq_v[61:0], 2'b00};
      if (rem >= trial) begin
        s_d.sq_rem  = rem - trial;
        s_d.sq_root = {s_i.sq_root[30:0], 1'b1};
      end else begin
        s_d.sq_rem  = rem;
        s_d.sq_root = {s_i.sq_root[30:0], 1'b0};
      end
    end

    // cordic vectoring rotation
    xs = $signed(s_i.cx) >>> STEP;
    ys = $signed(s_i.cy) >>> STEP;
    at = cnalu_pkg::CZ_W'(cnalu_pkg::atan_q30(STEP));
    if (STEP < CORDIC_STEPS && STEP < cnalu_pkg::ATAN_ENTRIES && !s_i.cspec) begin
      if (!s_i.cy[cnalu_pkg::CX_W-1]) begin
        s_d.cx = s_i.cx + ys;
        s_d.cy = s_i.cy - xs;
        s_d.cz = s_i.cz + at;
      end else begin
        s_d.cx = s_i.cx - ys;
        s_d.cy = s_i.cy + xs;
        s_d.cz = s_i.cz - at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign s_o = s_q;

endmodule

// File: src/complex_number_alu_unit.sv
// Complex arithmetic unit on signed fixed point operands with FRAC_BITS
// fraction bits. An operation is transferred at a clock edge where start is
// high; busy is always low, so a new operation may be issued every cycle.
// mode_i selects add, sub, mul, div, compare, magnitude of a or argument of a.
// Each operation produces exactly one result: res_valid_o is high for one
// cycle once the operation has left the output stage, with res_re_o, res_im_o,
// equal_flag_o and status_o. Results leave in issue order.
// Throughput is one operation per cycle through three setup stages (products,
// sums, normalization), 33 iteration stages that each retire one quotient bit
// (the first 32 also a square root bit, the first CORDIC_STEPS, at most 24, also
// a cordic rotation), and an output stage that rounds and saturates.
// The receiver cannot hold results off; the pipeline never stalls.
// Reset clears all valid bits; operations in flight are dropped.
// status_o: 0 ok, 1 divide by zero (result 0), 2 saturated.
module complex_number_alu_unit #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               res_valid_o,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               equal_flag_o,
  output logic [1:0]         status_o
);

  localparam int NIT = cnalu_pkg::DIV_BITS;
  localparam int PRE_SH = cnalu_pkg::DIV_BITS - FRAC_BITS;
  localparam int ROUND_SH = cnalu_pkg::ANGLE_BITS - FRAC_BITS;
  localparam logic [35:0] ROUND_HALF = 36'd1 << (ROUND_SH - 1);

  assign busy = 1'b0;

  // stage 0: operand registers
  logic v0_q;
  logic [2:0] mode0_q;
  logic signed [31:0] ar0_q, ai0_q, br0_q, bi0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    mode0_q <= mode_i;
    ar0_q   <= a_re_i;
    ai0_q   <= a_im_i;
    br0_q   <= b_re_i;
    bi0_q   <= b_im_i;
  end

  // stage 1: products, add/sub, cordic quadrant fold
  logic v1_q;
  logic [2:0] mode1_q;
  logic eq1_q;
  logic signed [63:0] p_rr_d, p_ii_d, p_ri_d, p_ir_d;
  logic signed [63:0] q_ar_d, q_ai_d, q_br_d, q_bi_d;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [63:0] q_ar_q, q_ai_q, q_br_q, q_bi_q;
  logic [32:0] sre_d, sim_d, sre_q, sim_q;
  logic [32:0] ar_x, ai_x, br_x, bi_x;
  logic [32:0] xn_d, yn_d, ay, m_d;
  logic [32:0] xn1_q, yn1_q, m1_q;
  logic [cnalu_pkg::CZ_W-1:0] z0_d, z1_q;
  logic spec_d, spec1_q;

  always_comb begin
    ar_x = {ar0_q[31], ar0_q};
    ai_x = {ai0_q[31], ai0_q};
    br_x = {br0_q[31], br0_q};
    bi_x = {bi0_q[31], bi0_q};
    p_rr_d = $signed(ar0_q) * $signed(br0_q);
    p_ii_d = $signed(ai0_q) * $signed(bi0_q);
    p_ri_d = $signed(ar0_q) * $signed(bi0_q);
    p_ir_d = $signed(ai0_q) * $signed(br0_q);
    q_ar_d = $signed(ar0_q) * $signed(ar0_q);
    q_ai_d = $signed(ai0_q) * $signed(ai0_q);
    q_br_d = $signed(br0_q) * $signed(br0_q);
    q_bi_d = $signed(bi0_q) * $signed(bi0_q);
    if (mode0_q == cnalu_pkg::MODE_SUB) begin
      sre_d = ar_x - br_x;
      sim_d = ai_x - bi_x;
    end else begin
      sre_d = ar_x + br_x;
      sim_d = ai_x + bi_x;
    end
    // left half plane folds into the right one with a start angle of +-pi
    xn_d = ar0_q[31] ? 33'd0 - ar_x : ar_x;
    yn_d = ar0_q[31] ? 33'd0 - ai_x : ai_x;
    ay   = yn_d[32] ? 33'd0 - yn_d : yn_d;
    m_d  = (xn_d > ay) ? xn_d : ay;
    spec_d = (ai0_q == 32'sd0);
    if (spec_d) begin
      z0_d = ar0_q[31] ? cnalu_pkg::PI_Q30 : '0;
    end else if (ar0_q[31]) begin
      z0_d = ai0_q[31] ? ('0 - cnalu_pkg::PI_Q30) : cnalu_pkg::PI_Q30;
    end else begin
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= mode0_q;
    eq1_q   <= (ar0_q == br0_q) && (ai0_q == bi0_q);
    p_rr_q  <= p_rr_d;
    p_ii_q  <= p_ii_d;
    p_ri_q  <= p_ri_d;
    p_ir_q  <= p_ir_d;
    q_ar_q  <= q_ar_d;
    q_ai_q  <= q_ai_d;
    q_br_q  <= q_br_d;
    q_bi_q  <= q_bi_d;
    sre_q   <= sre_d;
    sim_q   <= sim_d;
    xn1_q   <= xn_d;
    yn1_q   <= yn_d;
    m1_q    <= m_d;
    z1_q    <= z0_d;
    spec1_q <= spec_d;
  end

  // stage 2: sums of products, add/sub saturation, normalize shift count
  logic v2_q;
  logic [2:0] mode2_q;
  logic eq2_q;
  logic [64:0] mre_q, mim_q, dre_q, dim_q;
  logic [63:0] den2_q, ssq2_q;
  cnalu_pkg::pack_t ea_re_d, ea_im_d, ea_re_q, ea_im_q;
  logic [32:0] sre_mag, sim_mag;
  logic [5:0] nsh_d, nsh_q;
  logic [32:0] xn2_q, yn2_q;
  logic [cnalu_pkg::CZ_W-1:0] z2_q;
  logic spec2_q;

  always_comb begin
    sre_mag = sre_q[32] ? 33'd0 - sre_q : sre_q;
    sim_mag = sim_q[32] ? 33'd0 - sim_q : sim_q;
    ea_re_d = cnalu_pkg::pack32(sre_q[32], 64'(sre_mag));
    ea_im_d = cnalu_pkg::pack32(sim_q[32], 64'(sim_mag));
    // shift that brings the larger coordinate to bit 39
    nsh_d = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (m1_q[i]) begin
        nsh_d = 6'(39 - i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode2_q <= mode1_q;
    eq2_q   <= eq1_q;
    mre_q   <= {p_rr_q[63], p_rr_q} - {p_ii_q[63], p_ii_q};
    mim_q   <= {p_ri_q[63], p_ri_q} + {p_ir_q[63], p_ir_q};
    dre_q   <= {p_rr_q[63], p_rr_q} + {p_ii_q[63], p_ii_q};
    dim_q   <= {p_ir_q[63], p_ir_q} - {p_ri_q[63], p_ri_q};
    den2_q  <= q_br_q + q_bi_q;
    ssq2_q  <= q_ar_q + q_ai_q;
    ea_re_q <= ea_re_d;
    ea_im_q <= ea_im_d;
    nsh_q   <= nsh_d;
    xn2_q   <= xn1_q;
    yn2_q   <= yn1_q;
    z2_q    <= z1_q;
    spec2_q <= spec1_q;
  end

  // stage 3: mul saturation, divider and root setup, cordic scaling
  logic v3_q;
  cnalu_pkg::side_t side3_d, side3_q;
  cnalu_pkg::iter_t it3_d, it3_q;
  logic [63:0] mre_mag, mim_mag, dre_mag, dim_mag, dre_sh, dim_sh;
  cnalu_pkg::pack_t mp_re, mp_im;

  always_comb begin
    mre_mag = mre_q[64] ? 64'(65'd0 - mre_q) : mre_q[63:0];
    mim_mag = mim_q[64] ? 64'(65'd0 - mim_q) : mim_q[63:0];
    dre_mag = dre_q[64] ? 64'(65'd0 - dre_q) : dre_q[63:0];
    dim_mag = dim_q[64] ? 64'(65'd0 - dim_q) : dim_q[63:0];
    mp_re = cnalu_pkg::pack32(mre_q[64], mre_mag >> FRAC_BITS);
    mp_im = cnalu_pkg::pack32(mim_q[64], mim_mag >> FRAC_BITS);
    dre_sh = dre_mag << FRAC_BITS;
    dim_sh = dim_mag << FRAC_BITS;

    side3_d.mode     = mode2_q;
    side3_d.eq       = eq2_q;
    if (mode2_q == cnalu_pkg::MODE_MUL) begin
      side3_d.e_re  = mp_re.val;
      side3_d.e_im  = mp_im.val;
      side3_d.e_sat = mp_re.sat | mp_im.sat;
    end else begin
      side3_d.e_re  = ea_re_q.val;
      side3_d.e_im  = ea_im_q.val;
      side3_d.e_sat = ea_re_q.sat | ea_im_q.sat;
    end
    side3_d.re_neg   = dre_q[64];
    side3_d.im_neg   = dim_q[64];
    // quotient of 2^33 or more saturates whatever its low bits
    side3_d.re_ovf   = (dre_mag >> PRE_SH) >= den2_q;
    side3_d.im_ovf   = (dim_mag >> PRE_SH) >= den2_q;
    side3_d.den_zero = (den2_q == 64'd0);

    it3_d.den     = den2_q;
    it3_d.dr_re   = dre_mag >> PRE_SH;
    it3_d.dq_re   = '0;
    it3_d.dn_re   = dre_sh[32:0];
    it3_d.dr_im   = dim_mag >> PRE_SH;
    it3_d.dq_im   = '0;
    it3_d.dn_im   = dim_sh[32:0];
    it3_d.sq_v    = ssq2_q;
    it3_d.sq_rem  = '0;
    it3_d.sq_root = '0;
    it3_d.cx      = {{(cnalu_pkg::CX_W-33){xn2_q[32]}}, xn2_q} << nsh_q;
    it3_d.cy      = {{(cnalu_pkg::CX_W-33){yn2_q[32]}}, yn2_q} << nsh_q;
    it3_d.cz      = z2_q;
    it3_d.cspec   = spec2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    it3_q   <= it3_d;
  end

  // iteration stages
  cnalu_pkg::iter_t it_s [NIT];
  cnalu_pkg::side_t side_q [NIT];
  logic [NIT-1:0] vit_q;

  for (genvar k = 0; k < NIT; k++) begin : g_it
    cnalu_iter_stage #(
      .STEP         (k),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_stage (
      .clk_i (clk_i),
      .s_i   ((k == 0) ? it3_q : it_s[(k == 0) ? 0 : k-1]),
      .s_o   (it_s[k])
    );

    always_ff @(posedge clk_i) begin
      side_q[k] <= (k == 0) ? side3_q : side_q[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vit_q <= '0;
    end else begin
      vit_q <= {vit_q[NIT-2:0], v3_q};
    end
  end

  // output stage
  cnalu_pkg::iter_t it_l;
  cnalu_pkg::side_t sd_l;
  cnalu_pkg::pack_t qp_re, qp_im, rp_mag, rp_arg;
  logic [cnalu_pkg::CZ_W-1:0] z_mag;
  logic [35:0] z_rnd;
  logic [31:0] re_d, im_d;
  logic [1:0] st_d;
  logic v_out_q;
  logic [31:0] re_q, im_q;
  logic eq_q;
  logic [1:0] st_q;

  always_comb begin
    it_l  = it_s[NIT-1];
    sd_l  = side_q[NIT-1];
    qp_re = cnalu_pkg::pack32(sd_l.re_neg, sd_l.re_ovf ? '1 : 64'(it_l.dq_re));
    qp_im = cnalu_pkg::pack32(sd_l.im_neg, sd_l.im_ovf ? '1 : 64'(it_l.dq_im));
    rp_mag = cnalu_pkg::pack32(1'b0, 64'(it_l.sq_root));
    z_mag = it_l.cz[cnalu_pkg::CZ_W-1] ? '0 - it_l.cz : it_l.cz;
    z_rnd = (36'(z_mag) + ROUND_HALF) >> ROUND_SH;
    rp_arg = cnalu_pkg::pack32(it_l.cz[cnalu_pkg::CZ_W-1], 64'(z_rnd));

    re_d = '0;
    im_d = '0;
    st_d = cnalu_pkg::ST_OK;
    case (sd_l.mode)
      cnalu_pkg::MODE_ADD, cnalu_pkg::MODE_SUB, cnalu_pkg::MODE_MUL: begin
        re_d = sd_l.e_re;
        im_d = sd_l.e_im;
        st_d = sd_l.e_sat ? cnalu_pkg::ST_SAT : cnalu_pkg::ST_OK;
      end
      cnalu_pkg::MODE_DIV: begin
        if (sd_l.den_zero) begin
          st_d = cnalu_pkg::ST_DIV0;
        end else begin
          re_d = qp_re.val;
          im_d = qp_im.val;
          st_d = (qp_re.sat | qp_im.sat) ? cnalu_pkg::ST_SAT : cnalu_pkg::ST_OK;
        end
      end
      cnalu_pkg::MODE_MAG: begin
        re_d = rp_mag.val;
        st_d = rp_mag.sat ? cnalu_pkg::ST_SAT : cnalu_pkg::ST_OK;
      end
      cnalu_pkg::MODE_ARG: begin
        re_d = rp_arg.val;
        st_d = rp_arg.sat ? cnalu_pkg::ST_SAT : cnalu_pkg::ST_OK;
      end
      default: begin
        re_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else begin
      v_out_q <= vit_q[NIT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
    eq_q <= sd_l.eq;
    st_q <= st_d;
  end

  assign res_valid_o  = v_out_q;
  assign res_re_o     = re_q;
  assign res_im_o     = im_q;
  assign equal_flag_o = eq_q;
  assign status_o     = st_q;

endmodule

// File: tb/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int ROT_STEPS = 16;
  localparam int PIPE_DRAIN = 60;
  localparam int STALL_LIMIT = 3000;
  localparam longint PI_ANGLE = 64'd3373259426;

  // atan(2^-k) in Q30
  localparam longint ROT_ANGLE [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } cx_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         mode_i = '0;
  logic signed [31:0] a_re_i = '0;
  logic signed [31:0] a_im_i = '0;
  logic signed [31:0] b_re_i = '0;
  logic signed [31:0] b_im_i = '0;
  logic               res_valid_o;
  logic signed [31:0] res_re_o;
  logic signed [31:0] res_im_o;
  logic               equal_flag_o;
  logic [1:0]         status_o;

  cx_result_t pending_q[$];
  int         err_cnt = 0;
  int         quiet_cycles = 0;

  complex_number_alu_unit #(.FRAC_BITS(FRAC), .CORDIC_STEPS(ROT_STEPS)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .a_re_i       (a_re_i),
    .a_im_i       (a_im_i),
    .b_re_i       (b_re_i),
    .b_im_i       (b_im_i),
    .res_valid_o  (res_valid_o),
    .res_re_o     (res_re_o),
    .res_im_o     (res_im_o),
    .equal_flag_o (equal_flag_o),
    .status_o     (status_o)
  );

  always #1 clk_i = ~clk_i;

  // {saturated, value}
  function automatic logic [32:0] clamp32(input logic neg, input logic [63:0] mag);
    if (!neg) begin
      if (mag > 64'h7fff_ffff) return {1'b1, 32'h7fff_ffff};
      return {1'b0, mag[31:0]};
    end
    if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, 32'd0 - mag[31:0]};
  endfunction

  function automatic logic [63:0] abs96(input logic signed [95:0] v);
    logic signed [95:0] a;
    a = (v < 0) ? -v : v;
    return a[63:0];
  endfunction

  // floor(n * 2^FRAC / d), capped at 2^40
  function automatic logic [63:0] fixed_quot(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] cap;
    cap = 64'd1 << 40;
    q = n / d;
    r = n % d;
    if (q > cap) q = cap;
    for (int k = 0; k < FRAC; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
      if (q > cap) q = cap;
    end
    return q;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // atan2(y, x) in Q30 by vectoring rotations
  function automatic longint vector_angle(input longint x, input longint y);
    longint z;
    longint nx;
    longint scale;
    longint m;
    z = 0;
    scale = 1;
    if (y == 0) return (x < 0) ? PI_ANGLE : 0;
    if (x < 0) begin
      z = (y > 0) ? PI_ANGLE : -PI_ANGLE;
      x = -x;
      y = -y;
    end
    m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
    while (m < (64'sd1 <<< 39)) begin
      m = m <<< 1;
      scale = scale * 2;
    end
    x = x * scale;
    y = y * scale;
    for (int k = 0; k < ROT_STEPS && k < 24; k++) begin
      if (y >= 0) begin
        nx = x + (y >>> k);
        y = y - (x >>> k);
        z = z + ROT_ANGLE[k];
      end else begin
        nx = x - (y >>> k);
        y = y + (x >>> k);
        z = z - ROT_ANGLE[k];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic cx_result_t alu_predict(input logic [2:0] mode, input logic [31:0] ar_u,
                                             input logic [31:0] ai_u, input logic [31:0] br_u,
                                             input logic [31:0] bi_u);
    cx_result_t r;
    logic signed [95:0] ar, ai, br, bi, pre, pim;
    logic [63:0] mre, mim, den;
    logic [32:0] pr, pi;
    longint z;
    ar = signed'(ar_u);
    ai = signed'(ai_u);
    br = signed'(br_u);
    bi = signed'(bi_u);
    pr = '0;
    pi = '0;
    r.st = cnalu_pkg::ST_OK;
    r.eq = (ar_u == br_u) && (ai_u == bi_u);
    case (mode)
      cnalu_pkg::MODE_ADD, cnalu_pkg::MODE_SUB: begin
        pre = (mode == cnalu_pkg::MODE_ADD) ? ar + br : ar - br;
        pim = (mode == cnalu_pkg::MODE_ADD) ? ai + bi : ai - bi;
        pr = clamp32(pre < 0, abs96(pre));
        pi = clamp32(pim < 0, abs96(pim));
      end
      cnalu_pkg::MODE_MUL: begin
        pre = ar * br - ai * bi;
        pim = ar * bi + ai * br;
        mre = abs96(pre) >> FRAC;
        mim = abs96(pim) >> FRAC;
        pr = clamp32(pre < 0 && mre != 0, mre);
        pi = clamp32(pim < 0 && mim != 0, mim);
      end
      cnalu_pkg::MODE_DIV: begin
        pre = br * br + bi * bi;
        den = pre[63:0];
        if (den == 0) begin
          r.st = cnalu_pkg::ST_DIV0;
        end else begin
          pre = ar * br + ai * bi;
          pim = ai * br - ar * bi;
          mre = fixed_quot(abs96(pre), den);
          mim = fixed_quot(abs96(pim), den);
          pr = clamp32(pre < 0 && mre != 0, mre);
          pi = clamp32(pim < 0 && mim != 0, mim);
        end
      end
      cnalu_pkg::MODE_MAG: begin
        pre = ar * ar + ai * ai;
        pr = clamp32(1'b0, floor_root(pre[63:0]));
      end
      cnalu_pkg::MODE_ARG: begin
        z = vector_angle(longint'(signed'(ar_u)), longint'(signed'(ai_u)));
        pre = z;
        mre = (abs96(pre) + 64'd8192) >> 14;
        pr = clamp32(z < 0 && mre != 0, mre);
      end
      default: ;
    endcase
    r.re = pr[31:0];
    r.im = pi[31:0];
    if ((pr[32] || pi[32]) && r.st == cnalu_pkg::ST_OK) r.st = cnalu_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    cx_result_t w;
    if (rst_ni && res_valid_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", res_re_o, 32'h0);
      end else begin
        w = pending_q.pop_front();
        if (res_re_o !== w.re) report_mismatch("res_re", res_re_o, w.re);
        if (res_im_o !== w.im) report_mismatch("res_im", res_im_o, w.im);
        if (equal_flag_o !== w.eq) begin
          report_mismatch("equal_flag", 32'(equal_flag_o), 32'(w.eq));
        end
        if (status_o !== w.st) report_mismatch("status", 32'(status_o), 32'(w.st));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("** complex_number_alu_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_op(input logic [2:0] mode, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    mode_i <= mode;
    a_re_i <= ar;
    a_im_i <= ai;
    b_re_i <= br;
    b_im_i <= bi;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(alu_predict(mode, ar, ai, br, bi));
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 11))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3, 4: return $urandom_range(0, 524288) - 262144;
      5, 6: return $urandom_range(0, 33554432) - 16777216;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_op(cnalu_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000);
    send_op(cnalu_pkg::MODE_ADD, 32'h0001_8000, 32'hffff_0000,
            32'h0000_8000, 32'h0002_0000);
    send_op(cnalu_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h8000_0000);
    send_op(cnalu_pkg::MODE_SUB, 32'h0003_0000, 32'h0001_0000,
            32'h0003_0000, 32'h0001_0000);
    send_op(cnalu_pkg::MODE_MUL, 32'h0002_0000, 32'h0003_0000,
            32'hffff_0000, 32'h0000_8000);
    send_op(cnalu_pkg::MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h8000_0000);
    send_op(cnalu_pkg::MODE_MUL, 32'h0000_0001, 32'hffff_ffff,
            32'h0000_0001, 32'h0000_0001);
    send_op(cnalu_pkg::MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_DIV, 32'h0001_0000, 32'h0002_0000,
            32'h0003_0000, 32'hfffc_0000);
    send_op(cnalu_pkg::MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_op(cnalu_pkg::MODE_DIV, 32'hffff_ffff, 32'h0000_0001,
            32'h7fff_ffff, 32'h8000_0000);
    send_op(cnalu_pkg::MODE_CMP, 32'h1234_5678, 32'h8000_0000,
            32'h1234_5678, 32'h8000_0000);
    send_op(cnalu_pkg::MODE_CMP, 32'h1234_5678, 32'h0, 32'h1234_5679, 32'h0);
    send_op(cnalu_pkg::MODE_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_ARG, 32'h0, 32'h0, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_ARG, 32'h0005_0000, 32'h0, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_ARG, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_ARG, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_ARG, 32'hffff_0000, 32'hffff_0000, 32'h0, 32'h0);
    send_op(cnalu_pkg::MODE_ARG, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
    send_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    idle_for(1);
  endtask

  task automatic test_random(input int count);
    int sent;
    int burst;
    logic drained;
    logic [2:0] mode;
    logic [31:0] ar, ai, br, bi;
    sent = 0;
    drained = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count && (drained || sent < count / 2); k++) begin
        mode = 3'($urandom_range(0, 7));
        ar = pick_operand();
        ai = pick_operand();
        br = pick_operand();
        bi = pick_operand();
        if ($urandom_range(0, 7) == 0) begin
          br = ar;
          bi = ai;
        end
        if (mode == cnalu_pkg::MODE_DIV && $urandom_range(0, 5) == 0) begin
          br = 0;
          bi = 0;
        end
        if (mode == cnalu_pkg::MODE_ARG && $urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1)) ai = 0;
          else ar = 0;
        end
        send_op(mode, ar, ai, br, bi);
        sent++;
      end
      if (!drained && sent == count / 2) begin
        // let the pipeline drain completely once
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 8));
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(680);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** complex_number_alu_unit: PASSED **");
    end else begin
      $display("** complex_number_alu_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: complex_number_alu_unit.f
src/cnalu_pkg.sv
src/cnalu_iter_stage.sv
src/complex_number_alu_unit.sv
tb/tb_top.sv
